/* rtl/core/sdt_pkg.sv */
// Shared types, codes and helpers for the soft deadline timer.
// No dependencies; used by every module under rtl/core.
package sdt_pkg;

   localparam int unsigned REQ_TDATA_W = 232;
   localparam int unsigned RSP_TDATA_W = 72;
   localparam int unsigned OP_W        = 3;

   localparam int unsigned CTL_ENABLE_BIT = 0;
   localparam int unsigned CTL_IMASK_BIT  = 1;
   // control bits that let an expired timer raise pending: enabled, unmasked
   localparam logic [1:0]  CTL_FIRING     = 2'b01;

   typedef enum logic [OP_W-1:0] {
      OP_READ_CTL     = 3'd0,
      OP_READ_TVAL    = 3'd1,
      OP_WRITE_CTL    = 3'd2,
      OP_WRITE_TVAL   = 3'd3,
      OP_POLL         = 3'd4,
      OP_ADD_STOLEN   = 3'd5,
      OP_CLEAR_STOLEN = 3'd6
   } op_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic [63:0]     counter_now;
      logic [63:0]     write_value;
      logic [2:0]      seed_ctl;
      logic [31:0]     seed_tval;
      logic [63:0]     stolen_delta;
   } req_type;

   typedef struct packed {
      logic [63:0] read_data;
      logic        pending;
   } rsp_type;

   function automatic logic [63:0] sext32(input logic [31:0] v);
      return {{32{v[31]}}, v};
   endfunction

   // signed deadline - now at or below zero
   function automatic logic expired(input logic [63:0] d);
      return (d == 64'd0) || d[63];
   endfunction

endpackage

/* rtl/core/sdt_in_stage.sv */
// Input register of the soft deadline timer: unpacks and holds one request item.
// Depends on sdt_pkg.
module sdt_in_stage (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [sdt_pkg::OP_W-1:0]            req_tuser,  // op
   // counter_now, write_value, seed_ctl, seed_tval, stolen_delta, zero pad
   input  logic [sdt_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  logic                                advance,
   output logic                                item_valid,
   output sdt_pkg::req_type                    item
);

   logic             valid_ff, valid_in;
   sdt_pkg::req_type item_ff, item_in;
   logic             take;

   assign req_tready = !valid_ff || advance;
   assign take       = req_tvalid && req_tready;
   assign valid_in   = take || (valid_ff && !advance);

   always_comb begin
      item_in              = item_ff;
      if (take) begin
         item_in.op           = req_tuser;
         item_in.counter_now  = req_tdata[63:0];
         item_in.write_value  = req_tdata[127:64];
         item_in.seed_ctl     = req_tdata[130:128];
         item_in.seed_tval    = req_tdata[162:131];
         item_in.stolen_delta = req_tdata[226:163];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

/* rtl/core/sdt_core.sv */
// Timer state and per-item datapath: seeding, CTL/TVAL access, stolen offset.
// Depends on sdt_pkg. The deadline is held in raw counter units (deadline + stolen).
module sdt_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  sdt_pkg::req_type item,
   output sdt_pkg::rsp_type result
);

   logic [63:0] dl_ff, dl_in;
   logic [63:0] stolen_ff, stolen_in;
   logic [1:0]  ctl_ff, ctl_in;
   logic        seeded_ff, seeded_in;

   logic [63:0] cnt, sext_seed, sext_wv, diff_pre, diff_post;
   logic [1:0]  ctl_eff;
   logic        reg_access, seeding, exp_pre;

   assign cnt       = item.counter_now;
   assign sext_seed = sdt_pkg::sext32(item.seed_tval);
   assign sext_wv   = sdt_pkg::sext32(item.write_value[31:0]);

   assign reg_access = item.op inside {sdt_pkg::OP_READ_CTL, sdt_pkg::OP_READ_TVAL,
                                       sdt_pkg::OP_WRITE_CTL, sdt_pkg::OP_WRITE_TVAL};
   assign seeding    = reg_access && !seeded_ff;

   assign diff_pre = seeding ? sext_seed : dl_ff - cnt;
   assign ctl_eff  = seeding ? item.seed_ctl[1:0] : ctl_ff;
   assign exp_pre  = sdt_pkg::expired(diff_pre);

   always_comb begin
      result.read_data = 64'd0;
      dl_in            = seeding ? cnt + sext_seed : dl_ff;
      diff_post        = diff_pre;
      ctl_in           = ctl_eff;
      seeded_in        = seeded_ff || seeding;
      stolen_in        = stolen_ff;
      case (item.op)
         sdt_pkg::OP_READ_CTL: begin
            result.read_data = {61'd0, ctl_eff[sdt_pkg::CTL_ENABLE_BIT] && exp_pre, ctl_eff};
         end
         sdt_pkg::OP_READ_TVAL: begin
            result.read_data = {32'd0, diff_pre[31:0]};
         end
         sdt_pkg::OP_WRITE_CTL: begin
            ctl_in = item.write_value[1:0];
         end
         sdt_pkg::OP_WRITE_TVAL: begin
            dl_in     = cnt + sext_wv;
            diff_post = sext_wv;
         end
         sdt_pkg::OP_POLL: begin
            result.read_data = {63'd0,
               seeded_ff && (ctl_ff == sdt_pkg::CTL_FIRING) && exp_pre};
         end
         sdt_pkg::OP_ADD_STOLEN: begin
            dl_in     = dl_ff + item.stolen_delta;
            stolen_in = stolen_ff + item.stolen_delta;
            diff_post = dl_ff + item.stolen_delta - cnt;
         end
         sdt_pkg::OP_CLEAR_STOLEN: begin
            dl_in     = dl_ff - stolen_ff;
            stolen_in = 64'd0;
            diff_post = dl_ff - stolen_ff - cnt;
         end
         default: begin
         end
      endcase
      result.pending = seeded_in && (ctl_in == sdt_pkg::CTL_FIRING)
                    && sdt_pkg::expired(diff_post);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dl_ff     <= 64'd0;
         stolen_ff <= 64'd0;
         ctl_ff    <= 2'd0;
         seeded_ff <= 1'b0;
      end else if (fire) begin
         dl_ff     <= dl_in;
         stolen_ff <= stolen_in;
         ctl_ff    <= ctl_in;
         seeded_ff <= seeded_in;
      end
   end

endmodule

/* rtl/core/sdt_out_stage.sv */
// Result register of the soft deadline timer: holds one result item until taken.
// Depends on sdt_pkg.
module sdt_out_stage (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            load,
   input  sdt_pkg::rsp_type                result,
   output logic                            can_load,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [sdt_pkg::RSP_TDATA_W-1:0] rsp_tdata   // read_data, pending, zero pad
);

   logic             valid_ff, valid_in;
   sdt_pkg::rsp_type data_ff, data_in;

   assign can_load = !valid_ff || rsp_tready;
   assign valid_in = load || (valid_ff && !rsp_tready);
   assign data_in  = load ? result : data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {7'd0, data_ff.pending, data_ff.read_data};

endmodule

/* rtl/core/soft_deadline_timer.sv */
// Soft deadline timer: shadow model of a CTL/TVAL compare-value timer.
// Top level; instantiates sdt_in_stage, sdt_core and sdt_out_stage, uses sdt_pkg.
//
// Usage:
//   req channel carries one access per item: op in req_tuser, the counter
//   sample, write data, seed control, seed TVAL and stolen delta in req_tdata.
//   rsp channel returns exactly one item per access: read_data and the
//   pending flag after the access.
// Path: an accepted request passes the input register, then the result
//   register, before its result item shows on rsp; while rsp stalls it
//   waits in the input register.
// Throughput: one item per cycle while rsp_tready is high; the state update
//   and the 64-bit deadline compare sit between the input and result registers.
// Reset: synchronous, active high. Clears the deadline, control bits,
//   stolen offset and the seeded flag, and empties both registers.
// Stall: while rsp_tready is low the result register holds its item; the
//   input register still takes one more item, then req_tready drops until
//   the result is taken.
module soft_deadline_timer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [sdt_pkg::OP_W-1:0]        req_tuser,  // op
   // counter_now, write_value, seed_ctl, seed_tval, stolen_delta, zero pad
   input  logic [sdt_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [sdt_pkg::RSP_TDATA_W-1:0] rsp_tdata   // read_data, pending, zero pad
);

   sdt_pkg::req_type item;
   sdt_pkg::rsp_type result;
   logic             item_valid, can_load, advance;

   assign advance = item_valid && can_load;

   sdt_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   sdt_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (item),
      .result (result)
   );

   sdt_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .result     (result),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

/* rtl/core/sdt_checker.sv */
// Port-level checks for the soft deadline timer, bound to the top level.
// Depends on sdt_pkg and soft_deadline_timer.
module sdt_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [sdt_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result item changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with empty result register");

   a_rdata_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[63:32] == 32'd0) && (rsp_tdata[71:65] == 7'd0))
      else $error("read data or pad bits out of range");

endmodule

bind soft_deadline_timer sdt_checker u_sdt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* tb/sv/testbench.sv */
// Self-checking bench for soft_deadline_timer: directed and random CTL/TVAL, poll and
// stolen-offset accesses with random stalls on both channels, checked by a built-in timer model.
// Depends on sdt_pkg and the soft_deadline_timer RTL.
module testbench;

   localparam logic [sdt_pkg::OP_W-1:0] OP_UNUSED      = 3'd7;
   localparam int                       WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic [sdt_pkg::OP_W-1:0] op;
      logic [63:0]              counter_now;
      logic [63:0]              write_value;
      logic [2:0]               seed_ctl;
      logic [31:0]              seed_tval;
      logic [63:0]              stolen_delta;
   } access_type;

   typedef struct packed {
      logic [63:0] read_data;
      logic        pending;
   } timer_result_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [sdt_pkg::OP_W-1:0]        req_tuser = '0;  // op
   // counter_now, write_value, seed_ctl, seed_tval, stolen_delta, zero pad
   logic [sdt_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [sdt_pkg::RSP_TDATA_W-1:0] rsp_tdata;       // read_data, pending, zero pad

   soft_deadline_timer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // timer model state
   logic [63:0] m_deadline = '0;
   logic [1:0]  m_ctl = '0;
   logic        m_seeded = 1'b0;
   logic [63:0] m_stolen = '0;

   access_type       access_queue[$];
   timer_result_type due_results[$];
   access_type       drv_item;
   timer_result_type drv_result;
   timer_result_type want;
   int               sent_count = 0;
   int               got_count = 0;
   int               mismatches = 0;
   int               stall_left = 0;
   int               quiet_cycles = 0;
   logic [63:0]      stim_tick = '0;

   function automatic logic past_due(input logic [63:0] now);
      logic [63:0] d;
      d = m_deadline - now;
      return (d == 64'd0) || d[63];
   endfunction

   function automatic logic firing(input logic [63:0] now);
      return m_seeded && (m_ctl == sdt_pkg::CTL_FIRING) && past_due(now);
   endfunction

   task automatic apply_access(input access_type a, output timer_result_type r);
      logic [63:0] now;
      logic [63:0] diff;
      now = a.counter_now - m_stolen;
      r.read_data = '0;
      if (a.op <= sdt_pkg::OP_WRITE_TVAL && !m_seeded) begin
         m_ctl = a.seed_ctl[1:0];
         m_deadline = now + {{32{a.seed_tval[31]}}, a.seed_tval};
         m_seeded = 1'b1;
      end
      diff = m_deadline - now;
      case (a.op)
         sdt_pkg::OP_READ_CTL: begin
            r.read_data = {61'd0, m_ctl[sdt_pkg::CTL_ENABLE_BIT] && past_due(now), m_ctl};
         end
         sdt_pkg::OP_READ_TVAL: r.read_data = {32'd0, diff[31:0]};
         sdt_pkg::OP_WRITE_CTL: m_ctl = a.write_value[1:0];
         sdt_pkg::OP_WRITE_TVAL: begin
            m_deadline = now + {{32{a.write_value[31]}}, a.write_value[31:0]};
         end
         sdt_pkg::OP_POLL: r.read_data = {63'd0, firing(now)};
         sdt_pkg::OP_ADD_STOLEN: m_stolen = m_stolen + a.stolen_delta;
         sdt_pkg::OP_CLEAR_STOLEN: m_stolen = '0;
         default: ;
      endcase
      r.pending = firing(a.counter_now - m_stolen);
   endtask

   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   task automatic queue_access(input logic [sdt_pkg::OP_W-1:0] op, input logic [63:0] cnt,
                               input logic [63:0] wv, input logic [2:0] sctl,
                               input logic [31:0] stval, input logic [63:0] sdelta);
      access_type a;
      a.op = op;
      a.counter_now = cnt;
      a.write_value = wv;
      a.seed_ctl = sctl;
      a.seed_tval = stval;
      a.stolen_delta = sdelta;
      access_queue.push_back(a);
   endtask

   // time moves forward in small steps with rare jumps; TVAL writes mostly land
   // near now so the deadline keeps crossing it
   task automatic queue_random_run(input int count);
      int          pick;
      logic [2:0]  op;
      logic [63:0] wv;
      logic [63:0] delta;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 20) op = sdt_pkg::OP_READ_CTL;
         else if (pick < 35) op = sdt_pkg::OP_READ_TVAL;
         else if (pick < 47) op = sdt_pkg::OP_WRITE_CTL;
         else if (pick < 65) op = sdt_pkg::OP_WRITE_TVAL;
         else if (pick < 85) op = sdt_pkg::OP_POLL;
         else if (pick < 91) op = sdt_pkg::OP_ADD_STOLEN;
         else if (pick < 95) op = sdt_pkg::OP_CLEAR_STOLEN;
         else op = OP_UNUSED;
         if ($urandom_range(0, 39) == 0) stim_tick = rand_word();
         else stim_tick = stim_tick + $urandom_range(0, 40);
         wv = rand_word();
         if ($urandom_range(0, 3) != 0) wv[31:0] = $urandom_range(0, 400) - 200;
         delta = ($urandom_range(0, 4) == 0) ? rand_word() : 64'($urandom_range(0, 60));
         queue_access(op, stim_tick, wv, 3'($urandom_range(0, 7)), $urandom, delta);
      end
   endtask

   task automatic drain();
      while (access_queue.size() != 0 || req_tvalid || due_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic report(input string what, input logic [63:0] exp_v, input logic [63:0] got_v);
      mismatches++;
      $display("%0t %s mismatch: expected %h actual %h", $time, what, exp_v, got_v);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            apply_access(drv_item, drv_result);
            due_results.push_back(drv_result);
            sent_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (access_queue.size() != 0 &&
                ((sent_count >= 450 && sent_count < 600) || $urandom_range(0, 99) >= 20)) begin
               drv_item = access_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= drv_item.op;
               req_tdata <= {5'd0, drv_item.stolen_delta, drv_item.seed_tval,
                             drv_item.seed_ctl, drv_item.write_value, drv_item.counter_now};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (due_results.size() == 0) begin
               report("unexpected item", '0, rsp_tdata[63:0]);
            end else begin
               want = due_results.pop_front();
               if (rsp_tdata[63:0] !== want.read_data)
                  report("read_data", want.read_data, rsp_tdata[63:0]);
               if (rsp_tdata[64] !== want.pending)
                  report("pending", 64'(want.pending), 64'(rsp_tdata[64]));
            end
            got_count++;
            if (got_count == 300) stall_left = 80;
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= (got_count >= 450 && got_count < 600) || $urandom_range(0, 99) >= 20;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      // unseeded: poll, stolen ops and the unused op must not seed
      queue_access(sdt_pkg::OP_POLL, 64'd5, rand_word(), 3'b111, 32'hFFFF_FFFF, 64'd0);
      queue_access(sdt_pkg::OP_ADD_STOLEN, 64'd0, 64'd0, 3'b001, 32'd0, 64'd3);
      queue_access(OP_UNUSED, 64'd0, rand_word(), 3'b011, 32'd7, 64'd9);
      queue_access(sdt_pkg::OP_CLEAR_STOLEN, 64'd0, 64'd0, 3'b001, 32'd0, 64'd0);
      queue_access(sdt_pkg::OP_ADD_STOLEN, 64'd0, 64'd0, 3'b000, 32'd0, '1);
      // first access seeds; seed control bit2 ignored
      queue_access(sdt_pkg::OP_READ_TVAL, 64'd1000, '1, 3'b101, 32'd16, 64'd0);
      queue_access(sdt_pkg::OP_WRITE_CTL, 64'd1001, 64'hFFFF_FFFF_FFFF_FFFD, 3'b010,
                   32'h7FFF_FFFF, '1);
      queue_access(sdt_pkg::OP_READ_CTL, 64'd1010, 64'd0, 3'b000, 32'd0, 64'd0);
      queue_access(sdt_pkg::OP_READ_CTL, 64'd1016, 64'd0, 3'b000, 32'd0, 64'd0);
      queue_access(sdt_pkg::OP_POLL, 64'd1016, 64'd0, 3'b000, 32'd0, 64'd0);
      queue_access(sdt_pkg::OP_WRITE_TVAL, 64'd1100, 64'hAAAA_AAAA_8000_0000, 3'b000,
                   32'd0, 64'd0);
      queue_access(sdt_pkg::OP_READ_TVAL, 64'd1101, 64'd0, 3'b000, 32'd0, 64'd0);
      queue_access(sdt_pkg::OP_WRITE_TVAL, 64'd1200, 64'h5555_5555_7FFF_FFFF, 3'b000,
                   32'd0, 64'd0);
      queue_access(sdt_pkg::OP_READ_CTL, 64'd1201, 64'd0, 3'b000, 32'd0, 64'd0);
      queue_access(sdt_pkg::OP_WRITE_CTL, 64'd1202, 64'd3, 3'b000, 32'd0, 64'd0);
      queue_access(sdt_pkg::OP_POLL, '1, 64'd0, 3'b000, 32'd0, 64'd0);
      queue_access(sdt_pkg::OP_WRITE_CTL, 64'd1203, 64'd0, 3'b000, 32'd0, 64'd0);
      queue_access(sdt_pkg::OP_READ_CTL, '1, 64'd0, 3'b000, 32'd0, 64'd0);
      // counter wraps across the deadline
      queue_access(sdt_pkg::OP_WRITE_CTL, 64'hFFFF_FFFF_FFFF_FFF0, 64'd1, 3'b000, 32'd0, 64'd0);
      queue_access(sdt_pkg::OP_WRITE_TVAL, 64'hFFFF_FFFF_FFFF_FFF0, 64'h40, 3'b000, 32'd0,
                   64'd0);
      queue_access(sdt_pkg::OP_READ_TVAL, 64'h10, 64'd0, 3'b000, 32'd0, 64'd0);
      queue_access(sdt_pkg::OP_POLL, 64'h31, 64'd0, 3'b000, 32'd0, 64'd0);
      queue_access(sdt_pkg::OP_ADD_STOLEN, 64'h31, 64'd0, 3'b000, 32'd0,
                   64'h8000_0000_0000_0000);
      queue_access(sdt_pkg::OP_CLEAR_STOLEN, 64'h40, 64'd0, 3'b000, 32'd0, 64'd0);
      queue_access(OP_UNUSED, 64'h40, '1, 3'b111, '1, '1);
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      drain();
      stim_tick = 64'd2000;
      queue_random_run(375);
      drain();
      queue_random_run(375);
      drain();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
